### design/acs_pkg.sv
// acs_pkg: shared constants, register indexes, channel codes and the
// controller/datapath interface types of the ADC average/scale unit.
// No dependencies.
package acs_pkg;

    localparam int SCALE_DIVISOR = 1024;
    localparam int SAMPLE_BITS   = 10;
    localparam int UNITY_GAIN    = 10000;

    localparam int SUM_W   = 32;
    localparam int COUNT_W = 16;
    localparam int CFG_W   = 16;
    localparam int CH_W    = 3;
    localparam int VOLT_W  = 16;
    localparam int CFG_N   = 8;
    localparam int CFG_IDX_W = $clog2(CFG_N);

    // (x * UNITY_RECIP) >> UNITY_SHIFT equals x / UNITY_GAIN for every 32-bit x
    localparam logic [SUM_W-1:0] UNITY_RECIP = 32'hD1B7_1759;
    localparam int               UNITY_SHIFT = 45;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VDIFF_SCALE = 3'd0,
        REG_IDIFF_SCALE = 3'd1,
        REG_AB_SCALE    = 3'd2,
        REG_CD_SCALE    = 3'd3,
        REG_AB_GAIN     = 3'd4,
        REG_AB_OFFSET   = 3'd5,
        REG_CD_GAIN     = 3'd6,
        REG_CD_OFFSET   = 3'd7
    } cfg_index_t;

    typedef enum logic [CH_W-1:0] {
        CH_VDIFF = 3'd0,
        CH_IDIFF = 3'd1,
        CH_AB    = 3'd2,
        CH_CD    = 3'd3,
        CH_CD_AC = 3'd4
    } channel_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;     // input transaction this cycle
        logic load_run;   // accepted sample is the last of its run
        logic mul1;       // sum * scale, count * SCALE_DIVISOR
        logic div_start;  // launch the divider on the count term
        logic mul2;       // quotient * gain
        logic recip;      // divide by unity gain through the reciprocal
        logic finish;     // offset, clamp, load output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

### design/acs_divider.sv
// acs_divider: 32-bit unsigned restoring divider, one quotient bit per cycle.
// Depends on acs_pkg.
module acs_divider
    import acs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [SUM_W-1:0] divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(SUM_W);

    logic [SUM_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [SUM_W-1:0] dsor_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [SUM_W:0]   trial;
    logic [SUM_W:0]   diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[SUM_W-1]};
        diff  = trial - {1'b0, dsor_reg};
        if (!diff[SUM_W])
        begin
            rem_next = diff[SUM_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[SUM_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dsor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### design/acs_datapath.sv
// acs_datapath: configuration registers, run accumulator, multiply stages,
// serial divider and output register. Depends on acs_pkg, acs_divider.
module acs_datapath
    import acs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             status,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [CH_W-1:0]        channel,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [VOLT_W-1:0]      voltage,
    output logic [CH_W-1:0]        result_channel,
    output logic                   count_saturated
);

    logic [CFG_W-1:0]   cfg_reg [CFG_N];
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               ovf_reg, ovf_next;

    logic [SUM_W-1:0]   acc_reg;
    logic [COUNT_W-1:0] cnt_work_reg;
    logic               ovf_work_reg;
    logic [CH_W-1:0]    ch_reg;
    logic [CFG_W-1:0]   scale_reg, gain_reg, offset_reg;
    logic [CFG_W-1:0]   scale_sel, gain_sel, offset_sel;
    logic [SUM_W-1:0]   prod_reg;
    logic [SUM_W-1:0]   dsor_reg;

    logic [SUM_W-1:0]   quotient;
    logic               div_done;
    logic [2*SUM_W-1:0] recip_prod;
    logic [SUM_W-1:0]   unity_q_reg;
    logic [SUM_W-1:0]   final_sum;

    logic               out_valid_reg;
    logic [VOLT_W-1:0]  voltage_reg;
    logic [CH_W-1:0]    result_channel_reg;
    logic               count_saturated_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_N; i++)
                cfg_reg[i] <= (i == REG_AB_GAIN || i == REG_CD_GAIN)
                              ? CFG_W'(UNITY_GAIN) : '0;
        end
        else if (cfg_write)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // run accumulation; count sticks at its maximum and flags overflow
    always_comb
    begin
        sum_next = sum_reg + SUM_W'(sample);
        if (count_reg == {COUNT_W{1'b1}})
        begin
            count_next = count_reg;
            ovf_next   = 1'b1;
        end
        else
        begin
            count_next = count_reg + 1'b1;
            ovf_next   = ovf_reg;
        end
    end

    always_comb
    begin
        scale_sel  = '0;
        gain_sel   = CFG_W'(UNITY_GAIN);
        offset_sel = '0;
        case (channel)
            CH_VDIFF: scale_sel = cfg_reg[REG_VDIFF_SCALE];
            CH_IDIFF: scale_sel = cfg_reg[REG_IDIFF_SCALE];
            CH_AB:
            begin
                scale_sel  = cfg_reg[REG_AB_SCALE];
                gain_sel   = cfg_reg[REG_AB_GAIN];
                offset_sel = cfg_reg[REG_AB_OFFSET];
            end
            CH_CD:
            begin
                scale_sel  = cfg_reg[REG_CD_SCALE];
                gain_sel   = cfg_reg[REG_CD_GAIN];
                offset_sel = cfg_reg[REG_CD_OFFSET];
            end
            CH_CD_AC:
            begin
                scale_sel = cfg_reg[REG_CD_SCALE];
                gain_sel  = cfg_reg[REG_CD_GAIN];
            end
            default: scale_sel = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.load_run)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.accept)
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign recip_prod = (2*SUM_W)'(prod_reg) * (2*SUM_W)'(UNITY_RECIP);

    // working copy of the finished run
    always_ff @(posedge clk)
    begin
        if (cmd.load_run)
        begin
            acc_reg      <= sum_next;
            cnt_work_reg <= count_next;
            ovf_work_reg <= ovf_next;
            ch_reg       <= channel;
            scale_reg    <= scale_sel;
            gain_reg     <= gain_sel;
            offset_reg   <= offset_sel;
        end
        if (cmd.mul1)
        begin
            prod_reg <= acc_reg * SUM_W'(scale_reg);
            dsor_reg <= SUM_W'(cnt_work_reg) * SUM_W'(SCALE_DIVISOR);
        end
        else if (cmd.mul2)
        begin
            prod_reg <= quotient * SUM_W'(gain_reg);
        end
        // divide by unity gain: scaled reciprocal, keep the top bits
        if (cmd.recip)
            unity_q_reg <= SUM_W'(recip_prod >> UNITY_SHIFT);
    end

    acs_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (dsor_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign final_sum = unity_q_reg + {{(SUM_W-CFG_W){offset_reg[CFG_W-1]}}, offset_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // negative signed result clamps to zero
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            voltage_reg         <= final_sum[SUM_W-1] ? '0 : final_sum[VOLT_W-1:0];
            result_channel_reg  <= ch_reg;
            count_saturated_reg <= ovf_work_reg;
        end
    end

    assign status.div_done  = div_done;
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid       = out_valid_reg;
    assign voltage         = voltage_reg;
    assign result_channel  = result_channel_reg;
    assign count_saturated = count_saturated_reg;

endmodule

### design/acs_ctrl.sv
// acs_ctrl: sequencer for the end-of-run computation.
// Depends on acs_pkg.
module acs_ctrl
    import acs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       last_sample,
    output logic       in_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b000_0001,
        S_MUL1  = 7'b000_0010,
        S_DIV1S = 7'b000_0100,
        S_DIV1W = 7'b000_1000,
        S_MUL2  = 7'b001_0000,
        S_RECIP = 7'b010_0000,
        S_FIN   = 7'b100_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.accept   = in_valid;
                cmd.load_run = in_valid && last_sample;
                if (in_valid && last_sample)
                    state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_DIV1S;
            end
            S_DIV1S:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV1W;
            end
            S_DIV1W:
            begin
                if (status.div_done)
                    state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_RECIP;
            end
            S_RECIP:
            begin
                cmd.recip  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### design/adc_average_calibrated_scaler_unit.sv
// adc_average_calibrated_scaler_unit: top level of the ADC averaging and
// gain/offset calibration unit. Depends on acs_pkg, acs_ctrl, acs_datapath.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  input   | in_valid / in_stall  | sample, channel, last_sample
//  output  | out_valid / out_stall| voltage, result_channel, count_saturated
//  config  | cfg_write            | cfg_index, cfg_data
//
// A sample that is not last is accepted without a stall. A last sample holds in_stall
// high through the scale multiply, the 32-bit serial divider, the gain multiply,
// the reciprocal multiply for the unity-gain division and the final step.
// Reset clears the run state, the output valid and the registers to their
// defaults. A stalled output holds its result; the final step waits for it.
module adc_average_calibrated_scaler_unit
    import acs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [CH_W-1:0]        channel,
    input  logic                   last_sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [VOLT_W-1:0]      voltage,
    output logic [CH_W-1:0]        result_channel,
    output logic                   count_saturated
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    acs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .last_sample (last_sample),
        .in_stall    (in_stall),
        .status      (status),
        .cmd         (cmd)
    );

    acs_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .sample          (sample),
        .channel         (channel),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .voltage         (voltage),
        .result_channel  (result_channel),
        .count_saturated (count_saturated)
    );

endmodule

### design/acs_checker.sv
// acs_checker: port-level assertions for the ADC average/scale unit,
// bound to the top level. Depends on acs_pkg.
module acs_checker
    import acs_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              last_sample,
    input logic              out_valid,
    input logic              out_stall,
    input logic [VOLT_W-1:0] voltage,
    input logic [CH_W-1:0]   result_channel
);

    // a stalled result transaction stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(voltage) && $stable(result_channel))
        else $error("output payload changed while stalled");

    // the end-of-run computation blocks further input
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_sample |=> in_stall)
        else $error("input accepted right after a last sample");

    // a result cannot appear immediately after the last sample
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_sample |=> !$rose(out_valid))
        else $error("result appeared too early");

    // unknown channels scale by zero
    a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_channel > CH_CD_AC) |-> voltage == '0)
        else $error("unknown channel gave nonzero voltage");

endmodule

bind adc_average_calibrated_scaler_unit acs_checker u_acs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .last_sample    (last_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .voltage        (voltage),
    .result_channel (result_channel)
);

### dv/adc_average_calibrated_scaler_unit_test.sv
// Testbench for adc_average_calibrated_scaler_unit: random and directed sample runs,
// register settings per phase, results checked against an in-bench predictor.
// Depends on acs_pkg and the unit's RTL.
`timescale 1ns / 100ps

module adc_average_calibrated_scaler_unit_test;
    import acs_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 150;

    typedef struct packed {
        bit [VOLT_W-1:0] volt;
        bit [CH_W-1:0]   ch;
        bit              sat;
    } reading_t;

    // Predicts the scaled reading of each run and holds the readings still owed.
    class reading_scoreboard;
        bit [CFG_W-1:0]   regs [CFG_N];
        bit [SUM_W-1:0]   run_sum;
        bit [COUNT_W-1:0] run_count;
        bit               run_ovf;
        reading_t         readings_due[$];
        int               errors;

        function new();
            foreach (regs[i])
                regs[i] = '0;
            regs[REG_AB_GAIN] = CFG_W'(UNITY_GAIN);
            regs[REG_CD_GAIN] = CFG_W'(UNITY_GAIN);
            run_sum   = '0;
            run_count = '0;
            run_ovf   = 1'b0;
            errors    = 0;
        endfunction

        function void write_reg(cfg_index_t idx, bit [CFG_W-1:0] val);
            regs[idx] = val;
        endfunction

        function void take_sample(bit [SAMPLE_BITS-1:0] smp, bit [CH_W-1:0] ch, bit last);
            bit [31:0] scale;
            bit [31:0] gain;
            bit [31:0] offs;
            bit [31:0] acc;
            bit [31:0] div_term;
            reading_t  r;
            run_sum = run_sum + 32'(smp);
            if (run_count == {COUNT_W{1'b1}})
                run_ovf = 1'b1;
            else
                run_count = run_count + 1'b1;
            if (!last)
                return;
            gain = 32'(UNITY_GAIN);
            offs = '0;
            case (ch)
                CH_VDIFF: scale = 32'(regs[REG_VDIFF_SCALE]);
                CH_IDIFF: scale = 32'(regs[REG_IDIFF_SCALE]);
                CH_AB:
                begin
                    scale = 32'(regs[REG_AB_SCALE]);
                    gain  = 32'(regs[REG_AB_GAIN]);
                    offs  = {{16{regs[REG_AB_OFFSET][15]}}, regs[REG_AB_OFFSET]};
                end
                CH_CD:
                begin
                    scale = 32'(regs[REG_CD_SCALE]);
                    gain  = 32'(regs[REG_CD_GAIN]);
                    offs  = {{16{regs[REG_CD_OFFSET][15]}}, regs[REG_CD_OFFSET]};
                end
                CH_CD_AC:
                begin
                    scale = 32'(regs[REG_CD_SCALE]);
                    gain  = 32'(regs[REG_CD_GAIN]);
                end
                default: scale = '0;
            endcase
            // all steps wrap at 32 bits, unsigned
            div_term = 32'(run_count) * 32'(SCALE_DIVISOR);
            acc = run_sum * scale;
            acc = acc / div_term;
            acc = acc * gain;
            acc = acc / 32'(UNITY_GAIN);
            acc = acc + offs;
            if (acc[31])
                acc = '0;
            r.volt = acc[VOLT_W-1:0];
            r.ch   = ch;
            r.sat  = run_ovf;
            readings_due.push_back(r);
            run_sum   = '0;
            run_count = '0;
            run_ovf   = 1'b0;
        endfunction

        function void check_reading(bit [VOLT_W-1:0] volt, bit [CH_W-1:0] ch, bit sat);
            reading_t r;
            if (readings_due.size() == 0)
            begin
                $display("%0t: unexpected result: voltage %0d channel %0d saturated %0d",
                         $time, volt, ch, sat);
                errors++;
                return;
            end
            r = readings_due.pop_front();
            if (volt !== r.volt)
            begin
                $display("%0t: voltage mismatch: expected %0d, got %0d", $time, r.volt, volt);
                errors++;
            end
            if (ch !== r.ch)
            begin
                $display("%0t: result_channel mismatch: expected %0d, got %0d",
                         $time, r.ch, ch);
                errors++;
            end
            if (sat !== r.sat)
            begin
                $display("%0t: count_saturated mismatch: expected %0d, got %0d",
                         $time, r.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [SAMPLE_BITS-1:0] sample;
    logic [CH_W-1:0]        channel;
    logic                   last_sample;
    logic                   out_valid;
    logic                   out_stall;
    logic [VOLT_W-1:0]      voltage;
    logic [CH_W-1:0]        result_channel;
    logic                   count_saturated;

    reading_scoreboard board;
    int  cycle_count = 0;
    int  items_sent  = 0;
    int  burst_left  = 0;
    bit  hold_req    = 1'b0;
    int  hold_len    = 0;

    adc_average_calibrated_scaler_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .sample          (sample),
        .channel         (channel),
        .last_sample     (last_sample),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .voltage         (voltage),
        .result_channel  (result_channel),
        .count_saturated (count_saturated)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("tb: failure");
            $finish;
        end
    end

    // transaction monitors on both channels
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (out_valid && !out_stall)
                board.check_reading(voltage, result_channel, count_saturated);
            if (in_valid && !in_stall)
                board.take_sample(sample, channel, last_sample);
        end
    end

    // receiver: stall stretches of random density, long hold-off on request
    initial
    begin
        int stretch;
        int pct;
        out_stall = 1'b0;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                repeat (hold_len)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end
            else
            begin
                stretch = $urandom_range(10, 150);
                case ($urandom_range(0, 3))
                    0:       pct = 0;
                    1:       pct = 30;
                    2:       pct = 60;
                    default: pct = 90;
                endcase
                repeat (stretch)
                begin
                    @(negedge clk);
                    out_stall <= ($urandom_range(1, 100) <= pct);
                    if (hold_req)
                        break;
                end
            end
        end
    end

    task automatic send_item(input bit [SAMPLE_BITS-1:0] smp, input bit [CH_W-1:0] ch,
                             input bit last);
        @(negedge clk);
        in_valid    <= 1'b1;
        sample      <= smp;
        channel     <= ch;
        last_sample <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic idle(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // one sample inside the current burst; gaps between bursts
    task automatic offer(input bit [SAMPLE_BITS-1:0] smp, input bit [CH_W-1:0] ch,
                         input bit last);
        send_item(smp, ch, last);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            idle(($urandom_range(0, 9) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 8));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 10);
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input bit [CFG_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        board.write_reg(idx, val);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // wait for every owed result, then let any trailing work finish
    task automatic settle();
        while (board.readings_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin
        int                     run_len;
        int                     roll;
        int                     target;
        bit                     same_ch;
        bit [CH_W-1:0]          run_ch;
        bit [CH_W-1:0]          ch;
        bit [SAMPLE_BITS-1:0]   smp;
        bit [CFG_W-1:0]         val;

        board       = new();
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = REG_VDIFF_SCALE;
        cfg_data    = '0;
        in_valid    = 1'b0;
        sample      = '0;
        channel     = '0;
        last_sample = 1'b0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        idle(2);

        // directed: negative ab offset clamps, large cd offset, extreme vdiff scale
        write_reg(REG_VDIFF_SCALE, 16'hFFFF);
        write_reg(REG_IDIFF_SCALE, 16'h0001);
        write_reg(REG_AB_SCALE,    16'd5000);
        write_reg(REG_CD_SCALE,    16'd3300);
        write_reg(REG_AB_GAIN,     16'd10000);
        write_reg(REG_AB_OFFSET,   16'h8000);
        write_reg(REG_CD_GAIN,     16'd12000);
        write_reg(REG_CD_OFFSET,   16'h7FFF);

        send_item('0, CH_VDIFF, 1'b1);
        for (int c = 0; c < 8; c++)
            send_item({SAMPLE_BITS{1'b1}}, CH_W'(c), 1'b1);
        // channel codes change within a run; only the last one counts
        send_item(10'd512, 3'd5, 1'b0);
        send_item(10'd100, CH_IDIFF, 1'b0);
        send_item({SAMPLE_BITS{1'b1}}, CH_CD, 1'b1);
        for (int k = 0; k < 4; k++)
            send_item((k % 2) ? {SAMPLE_BITS{1'b1}} : '0, CH_AB, k == 3);
        idle(1);
        settle();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            for (int i = 0; i < CFG_N; i++)
            begin
                case (phase)
                    0: val = (i == REG_AB_OFFSET || i == REG_CD_OFFSET) ? 16'h7FFF : 16'hFFFF;
                    1: val = (i == REG_AB_OFFSET || i == REG_CD_OFFSET) ? 16'h8000 : 16'h0000;
                    2: val = (i == REG_AB_GAIN || i == REG_CD_GAIN)
                             ? CFG_W'($urandom_range(9000, 11000))
                             : CFG_W'($urandom_range(0, 65535));
                    default: val = CFG_W'($urandom_range(0, 65535));
                endcase
                write_reg(cfg_index_t'(i), val);
            end

            hold_len = $urandom_range(300, 500);
            hold_req = 1'b1;
            target   = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 75)
                    run_len = $urandom_range(1, 4);
                else if (roll < 98)
                    run_len = $urandom_range(5, 20);
                else
                    run_len = $urandom_range(21, 200);
                same_ch = ($urandom_range(0, 99) < 85);
                run_ch  = CH_W'($urandom_range(0, 7));
                for (int k = 0; k < run_len; k++)
                begin
                    case ($urandom_range(0, 9))
                        0:       smp = '0;
                        1:       smp = {SAMPLE_BITS{1'b1}};
                        default: smp = SAMPLE_BITS'($urandom_range(0, 1023));
                    endcase
                    ch = same_ch ? run_ch : CH_W'($urandom_range(0, 7));
                    offer(smp, ch, k == run_len - 1);
                end
            end
            idle(1);
            settle();
        end

        if (board.readings_due.size() != 0)
            $display("%0t: %0d results never arrived", $time, board.readings_due.size());
        if (board.errors == 0 && board.readings_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
